// File: sv/hppt_pkg.sv
// hppt_pkg: shared types and constants of the halfspace polygon point test
// depends on: nothing
package hppt_pkg;

	// fixed field widths
	localparam int OP_W       = 2;
	localparam int FACE_IDX_W = 4;
	localparam int FC_W       = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int FRAC_BITS  = 16;

	// operation codes
	localparam logic [OP_W-1:0] OP_FACE_WR  = 2'd0;
	localparam logic [OP_W-1:0] OP_PLANE_WR = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_XMIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_XMAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_YMIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_YMAX   = 3'd5;

	localparam logic [FC_W-1:0] FC_RESET = 5'd1;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic face_we;
		logic plane_we;
		logic issue_face;
		logic issue_plane;
		logic first;
		logic finish;
	} hppt_cmd_t;

	// tag that travels with each element through the dot product pipeline
	typedef struct packed {
		logic vld;
		logic plane;
		logic first;
	} hppt_tag_t;

endpackage

// File: sv/hppt_ram.sv
// hppt_ram: generic single write port, single read port RAM, registered read
// depends on: nothing
module hppt_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/hppt_ctrl.sv
// hppt_ctrl: controller of the point test, sequences face reads and the plane row
// depends on: hppt_pkg
module hppt_ctrl #(
	parameter int FACE_SLOTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [hppt_pkg::OP_W-1:0]         op,
	input  logic [hppt_pkg::FACE_IDX_W-1:0]   face_index,
	input  logic                              cfg_we,
	input  logic [hppt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hppt_pkg::FC_W-1:0]         cfg_fc,
	output logic                              busy,
	output hppt_pkg::hppt_cmd_t               cmd,
	output logic [$clog2(FACE_SLOTS)-1:0]     rd_addr
);
	import hppt_pkg::*;

	localparam int AW = $clog2(FACE_SLOTS);
	localparam int CW = ((AW > FC_W) ? AW : FC_W) + 1;
	localparam int IW = ((AW > FACE_IDX_W) ? AW : FACE_IDX_W) + 1;
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_ISSUE  = 5'b00010,
		S_PLANE  = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t          state_q, state_d;
	logic [AW-1:0]   k_q, last_q;
	logic [1:0]      drain_q;
	logic [FC_W-1:0] fc_q;
	logic            accept;
	logic [CW-1:0]   fc_ext, n_c;
	logic [AW-1:0]   last_c;
	logic            idx_ok;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// clamp the face count to one through FACE_SLOTS
	assign fc_ext = CW'(fc_q);
	always_comb begin
		priority if (fc_ext == '0) begin
			n_c = CW'(1);
		end else if (fc_ext > CW'(FACE_SLOTS)) begin
			n_c = CW'(FACE_SLOTS);
		end else begin
			n_c = fc_ext;
		end
	end
	assign last_c = AW'(n_c - CW'(1));

	// face writes beyond the table are dropped
	assign idx_ok = (IW'(face_index) < IW'(FACE_SLOTS));

	// command decode
	always_comb begin
		cmd.capture     = accept && (op == OP_QUERY);
		cmd.face_we     = accept && (op == OP_FACE_WR) && idx_ok;
		cmd.plane_we    = accept && (op == OP_PLANE_WR);
		cmd.issue_face  = (state_q == S_ISSUE);
		cmd.first       = (state_q == S_ISSUE) && (k_q == '0);
		cmd.issue_plane = (state_q == S_PLANE);
		cmd.finish      = (state_q == S_FINISH);
	end
	assign rd_addr = k_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (op == OP_QUERY)) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				if (k_q == last_q) begin
					state_d = S_PLANE;
				end
			end
			S_PLANE: begin
				state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (drain_q == DRAIN_LAST) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, face counter and drain counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			last_q  <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				k_q    <= '0;
				last_q <= last_c;
			end else if (state_q == S_ISSUE) begin
				k_q <= k_q + AW'(1);
			end
			if (state_q == S_PLANE) begin
				drain_q <= '0;
			end else if (state_q == S_DRAIN) begin
				drain_q <= drain_q + 2'd1;
			end
		end
	end

	// face count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= FC_RESET;
		end else if (cfg_we && (cfg_index == CFG_FACE_COUNT)) begin
			fc_q <= cfg_fc;
		end
	end

endmodule

// File: sv/hppt_dp.sv
// hppt_dp: datapath of the point test: face table, dot product pipeline, max and result
// depends on: hppt_pkg, hppt_ram
module hppt_dp #(
	parameter int FACE_SLOTS  = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hppt_pkg::hppt_cmd_t             cmd,
	input  logic [$clog2(FACE_SLOTS)-1:0]   rd_addr,
	input  logic [hppt_pkg::FACE_IDX_W-1:0] face_index,
	input  logic signed [COORD_WIDTH-1:0]   coord_x,
	input  logic signed [COORD_WIDTH-1:0]   coord_y,
	input  logic signed [COORD_WIDTH-1:0]   coord_z,
	input  logic signed [COORD_WIDTH-1:0]   offset,
	input  logic                            cfg_we,
	input  logic [hppt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_WIDTH-1:0]          cfg_wdata,
	output logic                            done,
	output logic signed [COORD_WIDTH-1:0]   violation,
	output logic [COORD_WIDTH-2:0]          plane_violation,
	output logic                            outside,
	output logic                            box_rejected
);
	import hppt_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int AW = $clog2(FACE_SLOTS);
	localparam int PW = 2 * W;
	localparam int SW = PW + 2;
	localparam int VW = 2 * W - 13;
	localparam logic signed [VW-1:0] VMAX = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {{(VW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic [VW-1:0]        PMAX = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};

	logic [4*W-1:0]        rdata;
	logic signed [W-1:0]   rd_nx, rd_ny, rd_nz, rd_off;
	logic signed [W-1:0]   px_q, py_q, pz_q;
	logic signed [W-1:0]   pl_nx_q, pl_ny_q, pl_nz_q, pl_off_q;
	logic                  box_en_q;
	logic signed [W-1:0]   box_xmin_q, box_xmax_q, box_ymin_q, box_ymax_q;
	hppt_tag_t             tag_s1, tag_s2, tag_s3;
	logic signed [W-1:0]   nx_m, ny_m, nz_m, off_m;
	logic signed [PW-1:0]  prod_x_s2, prod_y_s2, prod_z_s2;
	logic signed [W-1:0]   off_s2;
	logic signed [SW-1:0]  sum_c;
	logic signed [VW-1:0]  v_c, v_s3;
	logic [VW-1:0]         abs_c;
	logic signed [VW-1:0]  worst_q;
	logic [VW-1:0]         pabs_q;
	logic signed [W-1:0]   sat_worst_c;
	logic [W-2:0]          sat_plane_c;
	logic                  rej_c;
	logic                  done_q;
	logic signed [W-1:0]   viol_q;
	logic [W-2:0]          pviol_q;
	logic                  out_q, rej_q;

	// face table: normal x, y, z and offset in one row
	hppt_ram #(
		.WIDTH (4 * W),
		.DEPTH (FACE_SLOTS)
	) u_face_ram (
		.clk   (clk),
		.we    (cmd.face_we),
		.waddr (AW'(face_index)),
		.wdata ({coord_x, coord_y, coord_z, offset}),
		.re    (cmd.issue_face),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign rd_nx  = rdata[4*W-1:3*W];
	assign rd_ny  = rdata[3*W-1:2*W];
	assign rd_nz  = rdata[2*W-1:W];
	assign rd_off = rdata[W-1:0];

	// query point and plane row
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q <= coord_x;
			py_q <= coord_y;
			pz_q <= coord_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_nx_q  <= '0;
			pl_ny_q  <= '0;
			pl_nz_q  <= '0;
			pl_off_q <= '0;
		end else if (cmd.plane_we) begin
			pl_nx_q  <= coord_x;
			pl_ny_q  <= coord_y;
			pl_nz_q  <= coord_z;
			pl_off_q <= offset;
		end
	end

	// bounding box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_en_q   <= 1'b0;
			box_xmin_q <= '0;
			box_xmax_q <= '0;
			box_ymin_q <= '0;
			box_ymax_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOX_ENABLE: box_en_q   <= cfg_wdata[0];
				CFG_BOX_XMIN:   box_xmin_q <= cfg_wdata;
				CFG_BOX_XMAX:   box_xmax_q <= cfg_wdata;
				CFG_BOX_YMIN:   box_ymin_q <= cfg_wdata;
				CFG_BOX_YMAX:   box_ymax_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// element tags, aligned with the table read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1.vld   <= cmd.issue_face || cmd.issue_plane;
			tag_s1.plane <= cmd.issue_plane;
			tag_s1.first <= cmd.first;
			tag_s2       <= tag_s1;
			tag_s3       <= tag_s2;
		end
	end

	// multiply stage: face row or plane row times the point
	assign nx_m  = tag_s1.plane ? pl_nx_q  : rd_nx;
	assign ny_m  = tag_s1.plane ? pl_ny_q  : rd_ny;
	assign nz_m  = tag_s1.plane ? pl_nz_q  : rd_nz;
	assign off_m = tag_s1.plane ? pl_off_q : rd_off;

	always_ff @(posedge clk) begin
		prod_x_s2 <= nx_m * px_q;
		prod_y_s2 <= ny_m * py_q;
		prod_z_s2 <= nz_m * pz_q;
		off_s2    <= off_m;
	end

	// sum stage: exact sum, floor to q16.16, subtract offset
	assign sum_c = SW'(prod_x_s2) + SW'(prod_y_s2) + SW'(prod_z_s2);
	assign v_c   = VW'(sum_c >>> FRAC_BITS) - VW'(off_s2);

	always_ff @(posedge clk) begin
		v_s3 <= v_c;
	end

	// max stage for faces, magnitude for the plane
	assign abs_c = v_s3[VW-1] ? VW'(-v_s3) : VW'(v_s3);

	always_ff @(posedge clk) begin
		if (tag_s3.vld) begin
			if (tag_s3.plane) begin
				pabs_q <= abs_c;
			end else if (tag_s3.first || (v_s3 > worst_q)) begin
				worst_q <= v_s3;
			end
		end
	end

	// saturation and box check
	always_comb begin
		priority if (worst_q > VMAX) begin
			sat_worst_c = W'(VMAX);
		end else if (worst_q < VMIN) begin
			sat_worst_c = W'(VMIN);
		end else begin
			sat_worst_c = W'(worst_q);
		end
	end
	assign sat_plane_c = (pabs_q > PMAX) ? {(W-1){1'b1}} : (W-1)'(pabs_q);
	assign rej_c = box_en_q && ((px_q < box_xmin_q) || (px_q > box_xmax_q) ||
		(py_q < box_ymin_q) || (py_q > box_ymax_q));

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			viol_q  <= sat_worst_c;
			pviol_q <= sat_plane_c;
			rej_q   <= rej_c;
			out_q   <= rej_c || (!worst_q[VW-1] && (worst_q != '0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done            = done_q;
	assign violation       = viol_q;
	assign plane_violation = pviol_q;
	assign outside         = out_q;
	assign box_rejected    = rej_q;

endmodule

// File: sv/halfspace_polygon_point_test.sv
// halfspace_polygon_point_test: top level, joins controller and datapath
// depends on: hppt_pkg, hppt_ctrl, hppt_dp, hppt_ram
//
// A face write or plane write leaves busy low. A query
// keeps busy high and delivers its result with a one-cycle done strobe
// after n faces and the plane row, n being face_count clamped to 1..FACE_SLOTS.
// This sequence comes from the face table's single read port: one face per
// cycle enters a three-multiplier dot product pipeline, followed by the plane
// row, a pipeline drain and a final saturation step. Results cannot be held
// off: sample them in the cycle done is high. The next item may be started
// in that same cycle.
module halfspace_polygon_point_test #(
	parameter int FACE_SLOTS  = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [hppt_pkg::OP_W-1:0]       op,
	input  logic [hppt_pkg::FACE_IDX_W-1:0] face_index,
	input  logic signed [COORD_WIDTH-1:0]   coord_x,
	input  logic signed [COORD_WIDTH-1:0]   coord_y,
	input  logic signed [COORD_WIDTH-1:0]   coord_z,
	input  logic signed [COORD_WIDTH-1:0]   offset,
	input  logic                            cfg_we,
	input  logic [hppt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_WIDTH-1:0]          cfg_wdata,
	output logic                            done,
	output logic signed [COORD_WIDTH-1:0]   violation,
	output logic [COORD_WIDTH-2:0]          plane_violation,
	output logic                            outside,
	output logic                            box_rejected
);
	import hppt_pkg::*;

	hppt_cmd_t                     cmd;
	logic [$clog2(FACE_SLOTS)-1:0] rd_addr;

	// sequencer
	hppt_ctrl #(
		.FACE_SLOTS (FACE_SLOTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (op),
		.face_index (face_index),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_fc     (cfg_wdata[FC_W-1:0]),
		.busy       (busy),
		.cmd        (cmd),
		.rd_addr    (rd_addr)
	);

	// face table and arithmetic
	hppt_dp #(
		.FACE_SLOTS  (FACE_SLOTS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.rd_addr         (rd_addr),
		.face_index      (face_index),
		.coord_x         (coord_x),
		.coord_y         (coord_y),
		.coord_z         (coord_z),
		.offset          (offset),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.violation       (violation),
		.plane_violation (plane_violation),
		.outside         (outside),
		.box_rejected    (box_rejected)
	);

endmodule

// File: sv/hppt_checker.sv
// hppt_checker: port-level assertions for the point test, bound to the top level
// depends on: hppt_pkg, halfspace_polygon_point_test
module hppt_checker #(
	parameter int COORD_WIDTH = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [hppt_pkg::OP_W-1:0]     op,
	input logic                          done,
	input logic [COORD_WIDTH-1:0]        violation,
	input logic                          outside,
	input logic                          box_rejected
);
	import hppt_pkg::*;

	// an accepted query holds the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_QUERY)) |=> busy)
		else $error("query accepted but busy not raised");

	// writes complete in the beat they are accepted
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((op == OP_FACE_WR) || (op == OP_PLANE_WR))) |=> !busy)
		else $error("write left the block busy");

	// one result per query: no two strobes in a row
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one beat");

	// box rejection implies outside
	a_rej_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(done && box_rejected) |-> outside)
		else $error("box rejected but outside clear");

	// inside means the worst violation is not above zero
	a_inside_viol: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !outside) |-> (violation[COORD_WIDTH-1] || (violation == '0)))
		else $error("positive violation reported as inside");

endmodule

bind halfspace_polygon_point_test hppt_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_hppt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.op           (op),
	.done         (done),
	.violation    (violation),
	.outside      (outside),
	.box_rejected (box_rejected)
);

// File: sim/hppt_query_checker.sv
`timescale 1ns / 100ps
// hppt_query_checker: watches item, register and result beats of the point test,
// keeps its own copy of the face table and registers, and checks each query answer
// depends on: hppt_pkg
module hppt_query_checker #(
	parameter int FACE_SLOTS  = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [hppt_pkg::OP_W-1:0]       op,
	input  logic [hppt_pkg::FACE_IDX_W-1:0] face_index,
	input  logic signed [COORD_WIDTH-1:0]   coord_x,
	input  logic signed [COORD_WIDTH-1:0]   coord_y,
	input  logic signed [COORD_WIDTH-1:0]   coord_z,
	input  logic signed [COORD_WIDTH-1:0]   offset,
	input  logic                            cfg_we,
	input  logic [hppt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_WIDTH-1:0]          cfg_wdata,
	input  logic                            done,
	input  logic signed [COORD_WIDTH-1:0]   violation,
	input  logic [COORD_WIDTH-2:0]          plane_violation,
	input  logic                            outside,
	input  logic                            box_rejected,
	output int                              fail_count,
	output int                              pending,
	output int                              checked,
	output int                              outside_seen,
	output int                              rejected_seen
);
	import hppt_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int AW = 2 * CW + 4;
	localparam int PRINT_CAP = 100;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [AW-1:0] wide_t;

	typedef struct {
		coord_t        viol;
		logic [CW-2:0] plane_viol;
		logic          outside;
		logic          rejected;
	} answer_t;

	// halfspace table and plane row
	coord_t nrm_x[FACE_SLOTS];
	coord_t nrm_y[FACE_SLOTS];
	coord_t nrm_z[FACE_SLOTS];
	coord_t nrm_off[FACE_SLOTS];
	coord_t pln_x, pln_y, pln_z, pln_off;

	// register copies
	logic [FC_W-1:0] n_faces;
	logic            box_on;
	coord_t          x_lo, x_hi, y_lo, y_hi;

	answer_t answer_q[$];
	int      printed;

	// floor(n.p / 2^16) - b, formed exactly
	function automatic wide_t margin_of(input coord_t nx, ny, nz, b, px, py, pz);
		wide_t acc;
		acc = nx * px + ny * py + nz * pz;
		return (acc >>> FRAC_BITS) - b;
	endfunction

	// answer of one query point against the current table and registers
	function automatic answer_t predict_query(input coord_t px, py, pz);
		answer_t a;
		int      n;
		int      i;
		wide_t   v, worst, r, mag, top_lim, bot_lim;
		top_lim = (wide_t'(1) <<< (CW - 1)) - 1;
		bot_lim = -top_lim - 1;
		n = (n_faces == 0) ? 1 : (n_faces > FACE_SLOTS) ? FACE_SLOTS : int'(n_faces);
		worst = '0;
		for (i = 0; i < n; i++) begin
			v = margin_of(nrm_x[i], nrm_y[i], nrm_z[i], nrm_off[i], px, py, pz);
			if (i == 0 || v > worst)
				worst = v;
		end
		if (worst > top_lim)
			worst = top_lim;
		else if (worst < bot_lim)
			worst = bot_lim;
		a.viol = worst[CW-1:0];
		// plane residual magnitude, clipped to the positive range
		r = margin_of(pln_x, pln_y, pln_z, pln_off, px, py, pz);
		mag = (r < 0) ? -r : r;
		if (mag > top_lim)
			mag = top_lim;
		a.plane_viol = mag[CW-2:0];
		// strict box compares on x and y only
		a.rejected = box_on && (px < x_lo || px > x_hi || py < y_lo || py > y_hi);
		a.outside = a.rejected || (worst > 0);
		return a;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		fail_count++;
		if (printed < PRINT_CAP) begin
			printed++;
			$display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
		end
	endtask

	always @(posedge clk) begin : watch
		answer_t want;
		if (!arst_n) begin
			foreach (nrm_x[k]) begin
				nrm_x[k] = '0;
				nrm_y[k] = '0;
				nrm_z[k] = '0;
				nrm_off[k] = '0;
			end
			pln_x = '0;
			pln_y = '0;
			pln_z = '0;
			pln_off = '0;
			n_faces = FC_RESET;
			box_on = 1'b0;
			x_lo = '0;
			x_hi = '0;
			y_lo = '0;
			y_hi = '0;
			answer_q.delete();
			fail_count = 0;
			checked = 0;
			outside_seen = 0;
			rejected_seen = 0;
			printed = 0;
		end else begin
			// result beat against the oldest pending answer
			if (done) begin
				if (answer_q.size() == 0) begin
					flag_mismatch("result with no query pending", violation, 0);
				end else begin
					want = answer_q.pop_front();
					checked++;
					if (want.outside)
						outside_seen++;
					if (want.rejected)
						rejected_seen++;
					if (violation !== want.viol)
						flag_mismatch("violation", violation, want.viol);
					if (plane_violation !== want.plane_viol)
						flag_mismatch("plane_violation", plane_violation, want.plane_viol);
					if (outside !== want.outside)
						flag_mismatch("outside", outside, want.outside);
					if (box_rejected !== want.rejected)
						flag_mismatch("box_rejected", box_rejected, want.rejected);
				end
			end
			// register write
			if (cfg_we) begin
				case (cfg_index)
					CFG_FACE_COUNT: n_faces = cfg_wdata[FC_W-1:0];
					CFG_BOX_ENABLE: box_on = cfg_wdata[0];
					CFG_BOX_XMIN:   x_lo = cfg_wdata;
					CFG_BOX_XMAX:   x_hi = cfg_wdata;
					CFG_BOX_YMIN:   y_lo = cfg_wdata;
					CFG_BOX_YMAX:   y_hi = cfg_wdata;
					default: ;
				endcase
			end
			// item beat
			if (start && !busy) begin
				case (op)
					OP_FACE_WR: begin
						if (face_index < FACE_SLOTS) begin
							nrm_x[face_index] = coord_x;
							nrm_y[face_index] = coord_y;
							nrm_z[face_index] = coord_z;
							nrm_off[face_index] = offset;
						end
					end
					OP_PLANE_WR: begin
						pln_x = coord_x;
						pln_y = coord_y;
						pln_z = coord_z;
						pln_off = offset;
					end
					OP_QUERY: answer_q.push_back(predict_query(coord_x, coord_y, coord_z));
					default: ;
				endcase
			end
		end
		pending = answer_q.size();
	end

endmodule

// File: sim/tb_halfspace_polygon_point_test.sv
`timescale 1ns / 100ps
// tb_halfspace_polygon_point_test: stimulus and verdict for the halfspace point test
// depends on: hppt_pkg, halfspace_polygon_point_test, hppt_query_checker
module tb_halfspace_polygon_point_test;
	import hppt_pkg::*;

	localparam int FACE_SLOTS   = 16;
	localparam int COORD_WIDTH  = 32;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 25;
	localparam int RESET_CYCLES = 11;

	// spare op code, dropped by the block
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	localparam logic signed [31:0] C_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] C_MIN = 32'sh80000000;
	localparam logic signed [31:0] ONE   = 32'sh00010000;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [OP_W-1:0]               op;
	logic [FACE_IDX_W-1:0]         face_index;
	logic signed [COORD_WIDTH-1:0] coord_x, coord_y, coord_z, offset;
	logic                          cfg_we;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [COORD_WIDTH-1:0]        cfg_wdata;
	logic                          done;
	logic signed [COORD_WIDTH-1:0] violation;
	logic [COORD_WIDTH-2:0]        plane_violation;
	logic                          outside;
	logic                          box_rejected;

	int fail_count, pending, checked, outside_seen, rejected_seen;
	int items_sent;
	int settings_used;
	int quiet;

	// current box bounds, used to aim query points at the edges
	logic signed [31:0] bx_lo, bx_hi, by_lo, by_hi;

	halfspace_polygon_point_test #(
		.FACE_SLOTS (FACE_SLOTS),
		.COORD_WIDTH(COORD_WIDTH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.face_index     (face_index),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.coord_z        (coord_z),
		.offset         (offset),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.violation      (violation),
		.plane_violation(plane_violation),
		.outside        (outside),
		.box_rejected   (box_rejected)
	);

	hppt_query_checker #(
		.FACE_SLOTS (FACE_SLOTS),
		.COORD_WIDTH(COORD_WIDTH)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.face_index     (face_index),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.coord_z        (coord_z),
		.offset         (offset),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.violation      (violation),
		.plane_violation(plane_violation),
		.outside        (outside),
		.box_rejected   (box_rejected),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked        (checked),
		.outside_seen   (outside_seen),
		.rejected_seen  (rejected_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog on cycles with no item or result beat
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d queries pending", quiet, pending);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic logic signed [31:0] small_coord();
		return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
	endfunction

	// mix of full range, small values, extremes and values next to a pivot
	function automatic logic signed [31:0] pick_coord(input logic signed [31:0] pivot);
		int unsigned        roll;
		logic signed [31:0] v;
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
			v = $urandom;
		end else if (roll < 65) begin
			v = small_coord();
		end else if (roll < 75) begin
			case ($urandom_range(0, 4))
				0: v = C_MIN;
				1: v = C_MAX;
				2: v = 0;
				3: v = -1;
				default: v = ONE;
			endcase
		end else begin
			v = pivot + $signed($urandom_range(0, 4)) - 2;
		end
		return v;
	endfunction

	// one item beat, held until the block takes it
	task automatic put_item(input logic [OP_W-1:0] o, input logic [FACE_IDX_W-1:0] idx,
			input logic signed [31:0] x, y, z, off);
		@(negedge clk);
		op <= o;
		face_index <= idx;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		offset <= off;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// hold off until every query answer is back, then let the block go quiet
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input logic [FC_W-1:0] fc, input logic en,
			input logic signed [31:0] xl, xh, yl, yh);
		set_reg(CFG_FACE_COUNT, 32'(fc));
		set_reg(CFG_BOX_ENABLE, 32'(en));
		set_reg(CFG_BOX_XMIN, xl);
		set_reg(CFG_BOX_XMAX, xh);
		set_reg(CFG_BOX_YMIN, yl);
		set_reg(CFG_BOX_YMAX, yh);
		bx_lo = xl;
		bx_hi = xh;
		by_lo = yl;
		by_hi = yh;
		settings_used++;
	endtask

	// register setting per phase: extremes first, then mostly small face counts
	task automatic choose_setting(input int ph);
		logic [FC_W-1:0]    fc;
		logic signed [31:0] xl, yl;
		case (ph)
			0: apply_setting(5'd16, 1'b1, C_MIN, C_MAX, C_MIN, C_MAX);
			1: apply_setting(5'd31, 1'b1, C_MAX, C_MIN, C_MAX, C_MIN);
			2: apply_setting(5'd17, 1'b0, small_coord(), small_coord(), small_coord(),
					small_coord());
			default: begin
				if ($urandom_range(0, 3) == 0)
					fc = FC_W'($urandom_range(0, 31));
				else
					fc = FC_W'($urandom_range(1, 4));
				xl = small_coord();
				yl = small_coord();
				apply_setting(fc, 1'($urandom_range(0, 1)), xl,
						xl + $signed($urandom_range(0, 32'h80000)), yl,
						yl + $signed($urandom_range(0, 32'h80000)));
			end
		endcase
	endtask

	task automatic random_item();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			put_item(OP_QUERY, 4'($urandom),
					pick_coord($urandom_range(0, 1) ? bx_lo : bx_hi),
					pick_coord($urandom_range(0, 1) ? by_lo : by_hi),
					pick_coord(0), $urandom);
		else if (roll < 80)
			put_item(OP_FACE_WR, 4'($urandom_range(0, FACE_SLOTS - 1)), pick_coord(0),
					pick_coord(0), pick_coord(0), pick_coord(0));
		else if (roll < 92)
			put_item(OP_PLANE_WR, 4'($urandom), pick_coord(0), pick_coord(0),
					pick_coord(0), pick_coord(0));
		else
			put_item(OP_SPARE, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic run_phase(input int count, input bit gaps);
		repeat (count) begin
			random_item();
			if (gaps && $urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 10));
		end
	endtask

	initial begin
		int ph;
		int k;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_FACE_WR;
		face_index = '0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		offset = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_FACE_COUNT;
		cfg_wdata = '0;
		items_sent = 0;
		settings_used = 0;
		bx_lo = 0;
		bx_hi = 0;
		by_lo = 0;
		by_hi = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// reset registers: one face, box off; saturation both ways
		put_item(OP_FACE_WR, 4'd0, C_MAX, C_MAX, C_MAX, C_MIN);
		put_item(OP_QUERY, 4'd0, C_MAX, C_MAX, C_MAX, 0);
		put_item(OP_FACE_WR, 4'd0, C_MIN, C_MIN, C_MIN, C_MAX);
		put_item(OP_QUERY, 4'hf, C_MAX, C_MAX, C_MAX, C_MAX);
		put_item(OP_QUERY, 4'd0, C_MIN, C_MIN, C_MIN, 0);
		// plane residual clipped on both signs
		put_item(OP_PLANE_WR, 4'hf, C_MIN, C_MIN, C_MIN, C_MAX);
		put_item(OP_QUERY, 4'd0, C_MIN, C_MIN, C_MIN, 0);
		put_item(OP_QUERY, 4'd0, C_MAX, C_MAX, C_MAX, 0);
		// flooring of a fractional dot product, violation of exactly zero and one
		put_item(OP_FACE_WR, 4'd0, 1, 0, 0, 0);
		put_item(OP_QUERY, 4'd0, -1, 0, 0, 0);
		put_item(OP_QUERY, 4'd0, 32'sh0000ffff, 0, 0, 0);
		put_item(OP_QUERY, 4'd0, ONE, 0, 0, 0);
		// spare op gives no result
		put_item(OP_SPARE, 4'hf, C_MAX, C_MIN, C_MAX, C_MIN);
		drain();

		// face count zero acts as one face; strict box edges
		apply_setting(5'd0, 1'b1, -ONE, ONE, -ONE, ONE);
		put_item(OP_QUERY, 4'd0, -ONE, ONE, 0, 0);
		put_item(OP_QUERY, 4'd0, -ONE - 1, 0, 0, 0);
		put_item(OP_QUERY, 4'd0, ONE + 1, 0, 0, 0);
		put_item(OP_QUERY, 4'd0, 0, -ONE - 1, 0, 0);
		put_item(OP_QUERY, 4'd0, 0, ONE + 1, 0, 0);

		// fill the whole face table before any larger face count
		for (k = 0; k < FACE_SLOTS; k++)
			put_item(OP_FACE_WR, 4'(k), pick_coord(0), pick_coord(0), pick_coord(0),
					pick_coord(0));

		// random phases, one register setting each
		for (ph = 0; ph < 11; ph++) begin
			drain();
			choose_setting(ph);
			run_phase(100, (ph % 4) != 3);
		end
		// closing stretch without sender gaps
		drain();
		choose_setting(11);
		run_phase(150, 1'b0);
		drain();

		$display("covered %0d items over %0d register settings, %0d query answers compared",
				items_sent, settings_used, checked);
		$display("answers flagged outside: %0d, rejected by the box: %0d",
				outside_seen, rejected_seen);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
